// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SWU_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define SWU_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/swucb_pkg.sv =====
// Shared constants and types of the sliding-window UCB selector.
`timescale 1ns / 1ps
`default_nettype none
package swucb_pkg;

  localparam int MAX_ARMS        = 16;
  localparam int MAX_WINDOW      = 64;
  localparam int SCORE_FRAC_BITS = 16;

  localparam int ARM_W   = 4;
  localparam int ARM_IW  = $clog2(MAX_ARMS);
  localparam int ACNT_W  = 5;
  localparam int WLEN_W  = 7;
  localparam int TS_W    = 24;
  localparam int SCORE_W = SCORE_FRAC_BITS + 2;
  localparam int EST_W   = SCORE_FRAC_BITS + 1;

  // ln is built in Q.30: integer part, 30 fraction bits, then scaled by ln2
  localparam int MANT_W  = 31;
  localparam int FRAC_W  = 30;
  localparam int K_W     = 3;
  localparam int LN_W    = K_W + FRAC_W;
  localparam int ACC_W   = 63;
  localparam int NUM_SH  = 2 * SCORE_FRAC_BITS - 29;
  localparam int NUM_W   = LN_W + NUM_SH;
  localparam int ROOT_W  = NUM_W / 2;
  localparam logic [MANT_W-1:0] LN2_Q30 = 31'd744261118;

  // Request kinds on the input channel
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_CHOOSE = 1'b1;

  // Register indexes on the configuration port
  localparam logic REG_ARM_COUNT = 1'b0;
  localparam logic REG_WIN_LEN   = 1'b1;

  localparam logic [ACNT_W-1:0] ARM_COUNT_RST = 5'd16;
  localparam logic [WLEN_W-1:0] WIN_LEN_RST   = 7'd50;

  // Record command from the sequencer to the outcome store
  typedef struct packed {
    logic             start;
    logic [ARM_W-1:0] arm;
    logic             reward;
  } rec_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/swucb_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module swucb_div #(
  parameter int N_W = 36,
  parameter int D_W = 7
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [N_W-1:0] dividend,
  input  wire logic [D_W-1:0] divisor,
  output logic                done,
  output logic [N_W-1:0]      quotient
);

  localparam int C_W = $clog2(N_W + 1);

  logic [N_W-1:0] quo_r, quo_nxt;
  logic [D_W-1:0] rem_r, rem_nxt;
  logic [D_W-1:0] dsr_r;
  logic [C_W-1:0] cnt_r;
  logic           busy_r, done_r;
  logic [D_W:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, quo_r[N_W-1]};
    rem_nxt = trial[D_W-1:0];
    quo_nxt = {quo_r[N_W-2:0], 1'b0};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = D_W'(trial - {1'b0, dsr_r});
      quo_nxt[0] = 1'b1;
    end
  end

  // Advance the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == C_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= C_W'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == C_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/swucb_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module swucb_sqrt #(
  parameter int X_W = 36
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [X_W-1:0]   radicand,
  output logic                  done,
  output logic [X_W/2-1:0]      root
);

  localparam int R_W = X_W / 2;
  localparam int C_W = $clog2(R_W + 1);

  logic [X_W-1:0] x_r, res_r, bit_r;
  logic [X_W-1:0] x_nxt, res_nxt;
  logic [X_W:0]   trial;
  logic [C_W-1:0] cnt_r;
  logic           busy_r, done_r;

  // Compare against res + bit and subtract when it fits
  always_comb begin
    trial   = {1'b0, res_r} + {1'b0, bit_r};
    x_nxt   = x_r;
    res_nxt = res_r >> 1;
    if ({1'b0, x_r} >= trial) begin
      x_nxt   = X_W'({1'b0, x_r} - trial);
      res_nxt = (res_r >> 1) + bit_r;
    end
  end

  // Advance the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == C_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= C_W'(R_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == C_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  // Hold the remainder, root and bit weight
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      res_r <= '0;
      bit_r <= X_W'(1) << (X_W - 2);
    end else if (busy_r) begin
      x_r   <= x_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[R_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/swucb_ln.sv =====
// Natural log by repeated squaring on one shared multiplier, scaled to the bonus numerator.
`timescale 1ns / 1ps
`default_nettype none
module swucb_ln (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [swucb_pkg::WLEN_W-1:0]    n,
  output logic                                 done,
  output logic [swucb_pkg::NUM_W-1:0]          num
);

  localparam int MW = swucb_pkg::MANT_W;
  localparam int FW = swucb_pkg::FRAC_W;
  localparam int KW = swucb_pkg::K_W;
  localparam int AW = swucb_pkg::ACC_W;
  localparam int NW = swucb_pkg::WLEN_W;
  localparam int LO_W = 17;
  localparam int HI_W = swucb_pkg::LN_W - LO_W;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_SQ   = 5'b00010,
    L_LO   = 5'b00100,
    L_HI   = 5'b01000,
    L_ADD  = 5'b10000
  } ln_state_t;

  ln_state_t          state_r, state_nxt;
  logic [MW-1:0]      m_r;
  logic [FW-1:0]      frac_r;
  logic [KW-1:0]      k_r, k_c;
  logic [4:0]         cnt_r;
  logic [AW-1:0]      acc_r;
  logic [2*MW-1:0]    p_r;
  logic               done_r;
  logic [MW-1:0]      a_op, b_op;
  logic [2*MW-1:0]    prod;
  logic [MW:0]        sq;
  logic [KW+FW-1:0]   x_c;

  // Find the top set bit of n
  always_comb begin
    k_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (n[i]) k_c = KW'(i);
    end
  end

  assign x_c = {k_r, frac_r};

  // Select operands of the shared multiplier
  always_comb begin
    case (state_r)
      L_LO:    begin a_op = MW'(x_c[LO_W-1:0]);  b_op = swucb_pkg::LN2_Q30; end
      L_HI:    begin a_op = MW'(x_c[KW+FW-1:LO_W]); b_op = swucb_pkg::LN2_Q30; end
      default: begin a_op = m_r;                 b_op = m_r; end
    endcase
  end

  assign prod = a_op * b_op;
  assign sq   = prod[2*MW-1:FW];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:  if (start) state_nxt = L_SQ;
      L_SQ:    if (cnt_r == 5'(FW - 1)) state_nxt = L_LO;
      L_LO:    state_nxt = L_HI;
      L_HI:    state_nxt = L_ADD;
      L_ADD:   state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == L_ADD);
      if (start && state_r == L_IDLE) cnt_r <= '0;
      else if (state_r == L_SQ) cnt_r <= cnt_r + 1'b1;
    end
  end

  // Load n, square the mantissa, renormalize and collect one fraction bit per cycle, then scale by ln2
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          k_r    <= k_c;
          m_r    <= MW'({{(MW - NW){1'b0}}, n} << (5'(FW) - 5'(k_c)));
          frac_r <= '0;
        end
      end
      L_SQ: begin
        if (sq[MW]) begin
          m_r <= sq[MW:1];
          frac_r[5'(FW - 1) - cnt_r] <= 1'b1;
        end else begin
          m_r <= sq[MW-1:0];
        end
      end
      L_LO:  acc_r <= AW'(prod);
      L_HI:  p_r   <= prod;
      L_ADD: acc_r <= acc_r + {p_r[AW-LO_W-1:0], {LO_W{1'b0}}};
      default: ;
    endcase
  end

  assign done = done_r;
  assign num  = {acc_r[AW-1:FW], {swucb_pkg::NUM_SH{1'b0}}};

endmodule
`default_nettype wire

// ===== hw/rtl/swucb_store.sv =====
// Outcome ring and per-arm pull and reward counts with their update sequencer.
`timescale 1ns / 1ps
`default_nettype none
module swucb_store #(
  parameter int WIN   = swucb_pkg::MAX_WINDOW,
  parameter int CNT_W = $clog2(WIN + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire swucb_pkg::rec_req_t            rec,
  input  wire logic [CNT_W-1:0]               win_len,
  input  wire logic [swucb_pkg::ARM_IW-1:0]   rd_arm,
  output logic                                busy,
  output logic [CNT_W-1:0]                    rd_pulls,
  output logic [CNT_W-1:0]                    rd_rewards
);

  localparam int HW = (WIN > 1) ? $clog2(WIN) : 1;
  localparam int PW = CNT_W + 1;
  localparam int IW = swucb_pkg::ARM_IW;
  localparam int NA = swucb_pkg::MAX_ARMS;
  localparam int EW = swucb_pkg::ARM_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVR  = 5'b00010,
    ST_EVW  = 5'b00100,
    ST_INC  = 5'b01000,
    ST_INCW = 5'b10000
  } st_state_t;

  st_state_t          state_r, state_nxt;
  logic [EW-1:0]      ring_mem [WIN];
  logic [EW-1:0]      ring_q_r;
  logic [2*CNT_W-1:0] cnt_mem [NA];
  logic [2*CNT_W-1:0] cnt_q_r;
  logic               cnt_qv_r;
  logic [NA-1:0]      vld_r;
  logic [HW-1:0]      head_r, pos_r;
  logic [CNT_W-1:0]   fill_r;
  logic [IW-1:0]      arm_r, oa_r;
  logic               rew_r;
  logic [PW-1:0]      pos_sum;
  logic [IW-1:0]      raddr, waddr;
  logic               cnt_we, ring_we;
  logic [CNT_W-1:0]   cur_p, cur_r, new_p, new_r;
  logic               arm_ok;

  assign arm_ok = ({1'b0, rec.arm} < (swucb_pkg::ARM_W + 1)'(NA));

  // Place the new outcome after the newest one, wrapping around the ring
  always_comb begin
    pos_sum = PW'(head_r) + PW'(fill_r);
    if (pos_sum >= PW'(WIN)) pos_sum = pos_sum - PW'(WIN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (rec.start && arm_ok) begin
          state_nxt = (fill_r < win_len) ? ST_INC : ST_EVR;
        end
      end
      ST_EVR:  state_nxt = ST_EVW;
      ST_EVW:  state_nxt = ST_INC;
      ST_INC:  state_nxt = ST_INCW;
      ST_INCW: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Drop the evicted outcome or add the new one, and pick the count memory addresses
  always_comb begin
    cur_p = cnt_qv_r ? cnt_q_r[2*CNT_W-1:CNT_W] : '0;
    cur_r = cnt_qv_r ? cnt_q_r[CNT_W-1:0] : '0;
    if (state_r == ST_EVW) begin
      new_p = (cur_p != '0) ? cur_p - 1'b1 : cur_p;
      new_r = (cur_r >= CNT_W'(ring_q_r[0])) ? cur_r - CNT_W'(ring_q_r[0]) : cur_r;
      waddr = oa_r;
    end else begin
      new_p = cur_p + 1'b1;
      new_r = cur_r + CNT_W'(rew_r);
      waddr = arm_r;
    end
    cnt_we  = (state_r == ST_EVW) || (state_r == ST_INCW);
    ring_we = (state_r == ST_INC);
    case (state_r)
      ST_EVR:  raddr = IW'(ring_q_r[EW-1:1]);
      ST_INC:  raddr = arm_r;
      default: raddr = rd_arm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && rec.start && arm_ok && fill_r < win_len) begin
        fill_r <= fill_r + 1'b1;
      end
      if (state_r == ST_EVW) begin
        head_r <= (head_r == HW'(WIN - 1)) ? '0 : head_r + 1'b1;
      end
      if (cnt_we) vld_r[waddr] <= 1'b1;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && rec.start) begin
      arm_r <= IW'(rec.arm);
      rew_r <= rec.reward;
      pos_r <= HW'(pos_sum);
    end
    if (state_r == ST_EVR) oa_r <= raddr;
  end

  // Ring memory: read at the head, write at the tail
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[pos_r] <= {arm_r, rew_r};
    ring_q_r <= ring_mem[head_r];
  end

  // Count memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[waddr] <= {new_p, new_r};
    cnt_q_r  <= cnt_mem[raddr];
    cnt_qv_r <= vld_r[raddr];
  end

  assign busy       = (state_r != ST_IDLE);
  assign rd_pulls   = cur_p;
  assign rd_rewards = cur_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sliding_window_ucb_select_unit.sv =====
// Sliding-window UCB arm selector: top level with request sequencer and config registers.
// A record transfer (in_tuser = 0) appends an (arm, reward) outcome to the window and
// keeps the block busy until the store has updated its counts, longer when the oldest
// outcome is evicted. A choose transfer (in_tuser = 1) scores arms 0..arm_count-1 as
// rewards/pulls + sqrt(2*ln(min(window, t))/pulls) in unsigned Q2.16 and returns the arm
// with the greatest score, lowest index on ties. It keeps the block busy while ln is
// found on one shared multiplier (30 squarings) and then, for each arm in turn, while
// its pull and reward counts are read, the serial divider makes two passes and the square
// root runs, and longer while an earlier result still waits unread. in_tready is high
// only while no request is in flight; a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_ucb_select_unit #(
  parameter int MAX_WINDOW = swucb_pkg::MAX_WINDOW
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // arm[3:0], reward[4], time_step[28:5]
  input  wire logic        in_tuser,   // req_type[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // chosen_arm[3:0], best_score[21:4]
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int F     = swucb_pkg::SCORE_FRAC_BITS;
  localparam int NUMW  = swucb_pkg::NUM_W;
  localparam int SW    = swucb_pkg::SCORE_W;
  localparam int EW    = swucb_pkg::EST_W;
  localparam int RW    = swucb_pkg::ROOT_W;
  localparam int AC    = swucb_pkg::ACNT_W;
  localparam int WL    = swucb_pkg::WLEN_W;
  localparam int IW    = swucb_pkg::ARM_IW;

  typedef enum logic [8:0] {
    T_IDLE = 9'b000000001,
    T_REC  = 9'b000000010,
    T_LOG  = 9'b000000100,
    T_ARD  = 9'b000001000,
    T_ADAT = 9'b000010000,
    T_EST  = 9'b000100000,
    T_PAD  = 9'b001000000,
    T_ROOT = 9'b010000000,
    T_OUT  = 9'b100000000
  } top_state_t;

  top_state_t           state_r, state_nxt;
  logic [AC-1:0]        arm_count_r;
  logic [WL-1:0]        win_len_r;
  logic                 cfg_wr;
  logic                 in_acc;
  logic [WL-1:0]        len_c, n_c;
  logic [AC-1:0]        cnt_c, narm_r, idx_r;
  logic [NUMW-1:0]      num_r;
  logic [CNT_W-1:0]     dsr_r, pulls, rewards;
  logic [EW-1:0]        est_r;
  logic [SW-1:0]        best_r, ub_r;
  logic [IW-1:0]        best_arm_r, oarm_r;
  logic                 out_vld_r;
  logic [SW:0]          sum_c;
  logic [SW-1:0]        score_c;
  swucb_pkg::rec_req_t  rec;
  logic                 st_busy;
  logic                 ln_done, div_done, sq_done;
  logic [NUMW-1:0]      ln_num, div_q, div_n;
  logic [CNT_W-1:0]     div_d;
  logic                 div_start, sq_start;
  logic [RW-1:0]        root;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == swucb_pkg::REG_WIN_LEN) ? 32'(win_len_r)
                                                                : 32'(arm_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_count_r <= swucb_pkg::ARM_COUNT_RST;
      win_len_r   <= swucb_pkg::WIN_LEN_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == swucb_pkg::REG_ARM_COUNT) arm_count_r <= cfg_pwdata[AC-1:0];
      else win_len_r <= cfg_pwdata[WL-1:0];
    end
  end

  // Clamp the window, the log argument and the arm count
  always_comb begin
    if (win_len_r == '0) len_c = WL'(1);
    else if (32'(win_len_r) > 32'(MAX_WINDOW)) len_c = WL'(MAX_WINDOW);
    else len_c = win_len_r;
    if (in_tdata[28:5] > swucb_pkg::TS_W'(len_c)) n_c = len_c;
    else n_c = in_tdata[WL+4:5];
    if (n_c == '0) n_c = WL'(1);
    cnt_c = (32'(arm_count_r) > 32'(swucb_pkg::MAX_ARMS)) ? AC'(swucb_pkg::MAX_ARMS)
                                                         : arm_count_r;
  end

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign rec.start  = in_acc && (in_tuser == swucb_pkg::REQ_RECORD);
  assign rec.arm    = in_tdata[3:0];
  assign rec.reward = in_tdata[4];

  swucb_store #(.WIN(MAX_WINDOW), .CNT_W(CNT_W)) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec        (rec),
    .win_len    (CNT_W'(len_c)),
    .rd_arm     (IW'(idx_r)),
    .busy       (st_busy),
    .rd_pulls   (pulls),
    .rd_rewards (rewards)
  );

  swucb_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (in_tuser == swucb_pkg::REQ_CHOOSE)),
    .n     (n_c),
    .done  (ln_done),
    .num   (ln_num)
  );

  // Share one divider between the estimate and the bonus quotient
  assign div_start = (state_r == T_ADAT) || (state_r == T_EST && div_done);
  assign div_n     = (state_r == T_ADAT) ? NUMW'({rewards, {F{1'b0}}}) : num_r;
  assign div_d     = (state_r == T_ADAT) ? ((pulls != '0) ? pulls : CNT_W'(1)) : dsr_r;
  assign sq_start  = (state_r == T_PAD) && div_done;

  swucb_div #(.N_W(NUMW), .D_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  swucb_sqrt #(.X_W(NUMW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (div_q),
    .done     (sq_done),
    .root     (root)
  );

  // Add estimate and bonus, saturate
  always_comb begin
    sum_c   = (SW + 1)'(est_r) + (SW + 1)'(root);
    score_c = sum_c[SW] ? {SW{1'b1}} : sum_c[SW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE: begin
        if (in_acc) state_nxt = (in_tuser == swucb_pkg::REQ_CHOOSE) ? T_LOG : T_REC;
      end
      T_REC:  if (!st_busy) state_nxt = T_IDLE;
      T_LOG:  if (ln_done) state_nxt = (narm_r == '0) ? T_OUT : T_ARD;
      T_ARD:  state_nxt = T_ADAT;
      T_ADAT: state_nxt = T_EST;
      T_EST:  if (div_done) state_nxt = T_PAD;
      T_PAD:  if (div_done) state_nxt = T_ROOT;
      T_ROOT: if (sq_done) state_nxt = (idx_r + 1'b1 == narm_r) ? T_OUT : T_ARD;
      T_OUT:  if (!out_vld_r || out_tready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= T_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == T_OUT && (!out_vld_r || out_tready)) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  // Hold the running best and the per-arm operands
  always_ff @(posedge clk) begin
    case (state_r)
      T_IDLE: begin
        idx_r      <= '0;
        best_r     <= '0;
        best_arm_r <= '0;
        narm_r     <= cnt_c;
      end
      T_LOG:  num_r <= ln_num;
      T_ADAT: dsr_r <= div_d;
      T_EST:  if (div_done) est_r <= div_q[EW-1:0];
      T_ROOT: begin
        if (sq_done) begin
          idx_r <= idx_r + 1'b1;
          if (score_c > best_r) begin
            best_r     <= score_c;
            best_arm_r <= IW'(idx_r);
          end
        end
      end
      T_OUT: begin
        if (!out_vld_r || out_tready) begin
          ub_r   <= best_r;
          oarm_r <= best_arm_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, ub_r, oarm_r};

endmodule
`default_nettype wire

// ===== hw/rtl/swucb_checker.sv =====
// Port-level checker for the sliding-window UCB selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module swucb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        cfg_psel,
  input wire logic        cfg_pready
);

  // Stalled result holds
  `SWU_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // A choose request keeps the block busy in the next cycle
  `SWU_ASSERT_NXT(a_choose_busy, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready)
  // No result appears right after any transfer in
  `SWU_ASSERT_NXT(a_no_quick_out, clk, rst_n, in_tvalid && in_tready, !$rose(out_tvalid))
  // A new result follows a busy cycle
  `SWU_ASSERT_IMP(a_out_after_work, clk, rst_n, $rose(out_tvalid), !$past(in_tready))
  // Register port never waits
  `SWU_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_psel, cfg_pready)

endmodule

bind sliding_window_ucb_select_unit swucb_checker u_swucb_checker (.*);
`default_nettype wire
